// ----- rtl/rv32i_instruction_execute_unit_macros.svh -----
// ----------------------------------------------------------------------------
// rv32i execute unit assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define RV32I_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define RV32IEX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rv32iex assertion failed");

// next-cycle implication, quiet during reset
`define RV32IEX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rv32iex assertion failed");

`endif

// ----- rtl/rv32iex_pkg.sv -----
// ----------------------------------------------------------------------------
// rv32iex_pkg
// types, codes and constants of the rv32i execute unit
// ----------------------------------------------------------------------------
package rv32iex_pkg;

  localparam int XLEN      = 32;
  localparam int REG_COUNT = 32;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int CFG_AW    = 3;

  localparam logic [XLEN-1:0] RESET_PC_DEFAULT = 32'h0001_0000;

  // result status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_LOAD    = 3'd1;
  localparam logic [2:0] ST_SYS     = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  // memory request codes
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // major opcodes
  localparam logic [6:0] OPC_MASK   = 7'h7F;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_PRIV = 3'd0;

  localparam logic CFG_SEL_RESET_PC = 1'b0;

  typedef struct packed {
    logic            en;
    logic [4:0]      idx;
    logic [XLEN-1:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [XLEN-1:0] npc;
    logic [1:0]      mem_op;
    logic [1:0]      mem_size;
    logic [XLEN-1:0] mem_address;
    logic [XLEN-1:0] mem_write_data;
  } exe_res_t;

  typedef struct packed {
    logic       halt_set;
    logic       pend_set;
    logic       pend_clr;
    logic [4:0] pend_dest;
    logic [2:0] pend_type;
  } exe_upd_t;

endpackage

// ----- rtl/rv32iex_ifs.sv -----
// ----------------------------------------------------------------------------
// rv32iex channel interfaces
// valid/ready channels for instruction words and result words
// ----------------------------------------------------------------------------
interface rv32iex_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [rv32iex_pkg::XLEN-1:0]  instruction;
  logic [rv32iex_pkg::XLEN-1:0]  load_data;

  modport source (output valid, kind, instruction, load_data, input ready);
  modport sink   (input valid, kind, instruction, load_data, output ready);
endinterface

interface rv32iex_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [rv32iex_pkg::XLEN-1:0]  next_pc;
  logic [1:0]                    mem_op;
  logic [1:0]                    mem_size;
  logic [rv32iex_pkg::XLEN-1:0]  mem_address;
  logic [rv32iex_pkg::XLEN-1:0]  mem_write_data;

  modport source (output valid, status, next_pc, mem_op, mem_size, mem_address,
                  mem_write_data, input ready);
  modport sink   (input valid, status, next_pc, mem_op, mem_size, mem_address,
                  mem_write_data, output ready);
endinterface

// ----- rtl/rv32iex_regfile.sv -----
// ----------------------------------------------------------------------------
// rv32iex_regfile
// integer register file, two registered read ports, one write port with
// bypass, per-entry valid bits so reset reads as zero
// ----------------------------------------------------------------------------
module rv32iex_regfile (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [4:0]                   rs1_idx,
  input  logic [4:0]                   rs2_idx,
  input  rv32iex_pkg::rf_wr_t          wr,
  output logic [rv32iex_pkg::XLEN-1:0] rs1_data_r,
  output logic [rv32iex_pkg::XLEN-1:0] rs2_data_r
);
  import rv32iex_pkg::*;

  localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic                 wr_ok;
  logic [REG_IDX_W-1:0] wr_a;
  logic [REG_IDX_W-1:0] rs1_a;
  logic [REG_IDX_W-1:0] rs2_a;
  logic                 rs1_hit;
  logic                 rs2_hit;
  logic                 rs1_byp;
  logic                 rs2_byp;

  always_comb begin
    wr_ok   = wr.en && (wr.idx != 5'd0) && ({1'b0, wr.idx} < REG_LIMIT);
    wr_a    = wr.idx[REG_IDX_W-1:0];
    rs1_a   = rs1_idx[REG_IDX_W-1:0];
    rs2_a   = rs2_idx[REG_IDX_W-1:0];
    rs1_hit = (rs1_idx != 5'd0) && ({1'b0, rs1_idx} < REG_LIMIT) && vld_r[rs1_a];
    rs2_hit = (rs2_idx != 5'd0) && ({1'b0, rs2_idx} < REG_LIMIT) && vld_r[rs2_a];
    rs1_byp = wr_ok && (wr.idx == rs1_idx);
    rs2_byp = wr_ok && (wr.idx == rs2_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[wr_a] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_a] <= wr.data;
    end
    if (rd_en) begin
      if (rs1_byp) begin
        rs1_data_r <= wr.data;
      end else if (rs1_hit) begin
        rs1_data_r <= mem[rs1_a];
      end else begin
        rs1_data_r <= '0;
      end
      if (rs2_byp) begin
        rs2_data_r <= wr.data;
      end else if (rs2_hit) begin
        rs2_data_r <= mem[rs2_a];
      end else begin
        rs2_data_r <= '0;
      end
    end
  end

endmodule

// ----- rtl/rv32iex_exec.sv -----
// ----------------------------------------------------------------------------
// rv32iex_exec
// decode and execute of one word: alu, branch compare, address generation,
// load completion, result and state update
// ----------------------------------------------------------------------------
module rv32iex_exec (
  input  logic                         kind,
  input  logic [rv32iex_pkg::XLEN-1:0] insn,
  input  logic [rv32iex_pkg::XLEN-1:0] load_data,
  input  logic [rv32iex_pkg::XLEN-1:0] rs1,
  input  logic [rv32iex_pkg::XLEN-1:0] rs2,
  input  logic [rv32iex_pkg::XLEN-1:0] pc,
  input  logic                         halted,
  input  logic                         pend,
  input  logic [4:0]                   pend_dest,
  input  logic [2:0]                   pend_type,
  output rv32iex_pkg::exe_res_t        res,
  output rv32iex_pkg::exe_upd_t        upd,
  output rv32iex_pkg::rf_wr_t          wr
);
  import rv32iex_pkg::*;

  logic [6:0]      opc;
  logic [4:0]      rd;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [XLEN-1:0] imm_i;
  logic [XLEN-1:0] imm_s;
  logic [XLEN-1:0] imm_b;
  logic [XLEN-1:0] imm_j;
  logic [XLEN-1:0] imm_u;
  logic [XLEN-1:0] pc4;
  logic [XLEN-1:0] opb;
  logic            alt;
  logic [4:0]      sh;
  logic [XLEN-1:0] alu_y;
  logic [XLEN-1:0] agen;
  logic            eq;
  logic            lt_s;
  logic            lt_u;
  logic            take;
  logic            ok;
  logic [XLEN-1:0] ld_ext;

  always_comb begin
    opc   = insn[6:0] & OPC_MASK;
    rd    = insn[11:7];
    f3    = insn[14:12];
    f7    = insn[31:25];
    imm_i = {{20{insn[31]}}, insn[31:20]};
    imm_s = {{20{insn[31]}}, insn[31:25], insn[11:7]};
    imm_b = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
    imm_j = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
    imm_u = {insn[31:12], 12'b0};
    pc4   = pc + 32'd4;
    opb   = (opc == OPC_OP) ? rs2 : imm_i;
    alt   = ((opc == OPC_OP) && (f7 == F7_ALT)) ||
            ((opc == OPC_OPIMM) && (f3 == F3_SR) && (f7 == F7_ALT));
    sh    = opb[4:0];
    eq    = (rs1 == rs2);
    lt_s  = ($signed(rs1) < $signed(rs2));
    lt_u  = (rs1 < rs2);
    agen  = rs1 + ((opc == OPC_STORE) ? imm_s : imm_i);
  end

  always_comb begin
    case (f3)
      F3_ADD:  alu_y = alt ? (rs1 - opb) : (rs1 + opb);
      F3_SLL:  alu_y = rs1 << sh;
      F3_SLT:  alu_y = {31'b0, $signed(rs1) < $signed(opb)};
      F3_SLTU: alu_y = {31'b0, rs1 < opb};
      F3_XOR:  alu_y = rs1 ^ opb;
      F3_SR:   alu_y = alt ? $unsigned($signed(rs1) >>> sh) : (rs1 >> sh);
      F3_OR:   alu_y = rs1 | opb;
      default: alu_y = rs1 & opb;
    endcase
  end

  always_comb begin
    case (pend_type)
      F3_LB:   ld_ext = {{24{load_data[7]}}, load_data[7:0]};
      F3_LH:   ld_ext = {{16{load_data[15]}}, load_data[15:0]};
      F3_LBU:  ld_ext = {24'b0, load_data[7:0]};
      F3_LHU:  ld_ext = {16'b0, load_data[15:0]};
      default: ld_ext = load_data;
    endcase
  end

  always_comb begin
    case (f3)
      F3_BEQ:  take = eq;
      F3_BNE:  take = !eq;
      F3_BLT:  take = lt_s;
      F3_BGE:  take = !lt_s;
      F3_BLTU: take = lt_u;
      F3_BGEU: take = !lt_u;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    res     = '0;
    upd     = '0;
    wr      = '0;
    wr.idx  = rd;
    ok      = 1'b1;
    res.npc = pc;
    if (halted || (kind != pend)) begin
      res.status = ST_IGNORED;
    end else if (kind) begin
      res.status    = ST_DONE;
      wr.en         = 1'b1;
      wr.idx        = pend_dest;
      wr.data       = ld_ext;
      upd.pend_clr  = 1'b1;
    end else begin
      res.status = ST_DONE;
      res.npc    = pc4;
      unique case (opc)
        OPC_OP: begin
          ok      = (f7 == F7_BASE) || ((f7 == F7_ALT) && ((f3 == F3_ADD) || (f3 == F3_SR)));
          wr.en   = ok;
          wr.data = alu_y;
        end
        OPC_OPIMM: begin
          if (f3 == F3_SLL) begin
            ok = (f7 == F7_BASE);
          end else if (f3 == F3_SR) begin
            ok = (f7 == F7_BASE) || (f7 == F7_ALT);
          end
          wr.en   = ok;
          wr.data = alu_y;
        end
        OPC_LOAD: begin
          ok = (f3 == F3_LB) || (f3 == F3_LH) || (f3 == F3_LW) ||
               (f3 == F3_LBU) || (f3 == F3_LHU);
          upd.pend_set    = ok;
          upd.pend_dest   = rd;
          upd.pend_type   = f3;
          res.status      = ST_LOAD;
          res.mem_op      = MEM_READ;
          res.mem_size    = f3[1:0];
          res.mem_address = agen;
        end
        OPC_STORE: begin
          ok              = (f3 == F3_LB) || (f3 == F3_LH) || (f3 == F3_LW);
          res.mem_op      = MEM_WRITE;
          res.mem_size    = f3[1:0];
          res.mem_address = agen;
          case (f3[1:0])
            SZ_BYTE: res.mem_write_data = {24'b0, rs2[7:0]};
            SZ_HALF: res.mem_write_data = {16'b0, rs2[15:0]};
            default: res.mem_write_data = rs2;
          endcase
        end
        OPC_BRANCH: begin
          ok = (f3 != F3_SLT) && (f3 != F3_SLTU);
          if (take) begin
            res.npc = pc + imm_b;
          end
        end
        OPC_JALR: begin
          ok      = (f3 == F3_ADD);
          wr.en   = ok;
          wr.data = pc4;
          res.npc = {agen[XLEN-1:1], 1'b0};
        end
        OPC_LUI: begin
          wr.en   = 1'b1;
          wr.data = imm_u;
        end
        OPC_AUIPC: begin
          wr.en   = 1'b1;
          wr.data = pc + imm_u;
        end
        OPC_JAL: begin
          wr.en   = 1'b1;
          wr.data = pc4;
          res.npc = pc + imm_j;
        end
        OPC_SYSTEM: begin
          if (f3 == F3_PRIV) begin
            upd.halt_set = 1'b1;
            res.status   = ST_SYS;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
      if (!ok) begin
        res          = '0;
        res.status   = ST_ILLEGAL;
        res.npc      = pc;
        upd          = '0;
        upd.halt_set = 1'b1;
        wr.en        = 1'b0;
      end
    end
  end

endmodule

// ----- rtl/rv32i_instruction_execute_unit.sv -----
// ----------------------------------------------------------------------------
// rv32i_instruction_execute_unit
// rv32i execute unit: register file, pc, halt and pending-load state; one
// result word per accepted input word
// ----------------------------------------------------------------------------
//  channel  dir  handshake            word
//  in_if    in   valid/ready          kind, instruction, load_data
//  out_if   out  valid/ready          status, next_pc, mem_op/size/address/data
//  apb      in   psel/penable/pready  reset_pc at byte address 0
//
//  one word per cycle while out_if is not stalled; input and result are registered
//  operands are read from the register file on input accept, the word
//  executes from the input register when the result register is free or drained
//  a stalled result holds; one more input word is still taken meanwhile
//  rst_n is synchronous; the register file reads zero after reset
// ----------------------------------------------------------------------------
module rv32i_instruction_execute_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  rv32iex_in_if.sink                      in_if,
  rv32iex_out_if.source                   out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rv32iex_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rv32iex_pkg::*;

  logic            in_valid_r;
  logic            kind_r;
  logic [XLEN-1:0] insn_r;
  logic [XLEN-1:0] ld_data_r;
  logic            out_valid_r;
  exe_res_t        res_r;
  logic [XLEN-1:0] pc_r;
  logic            halted_r;
  logic            pend_r;
  logic [4:0]      pend_dest_r;
  logic [2:0]      pend_type_r;
  logic [XLEN-1:0] reset_pc_r;
  logic            in_go;
  logic            ex_go;
  logic            cfg_wr;
  logic [XLEN-1:0] rs1_data_r;
  logic [XLEN-1:0] rs2_data_r;
  exe_res_t        res;
  exe_upd_t        upd;
  rf_wr_t          rf_wr;
  rf_wr_t          rf_wr_g;

  assign ex_go        = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || ex_go;
  assign in_go        = in_if.valid && in_if.ready;
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == CFG_SEL_RESET_PC) ? reset_pc_r : '0;

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = res_r.status;
  assign out_if.next_pc        = res_r.npc;
  assign out_if.mem_op         = res_r.mem_op;
  assign out_if.mem_size       = res_r.mem_size;
  assign out_if.mem_address    = res_r.mem_address;
  assign out_if.mem_write_data = res_r.mem_write_data;

  always_comb begin
    rf_wr_g    = rf_wr;
    rf_wr_g.en = rf_wr.en && ex_go;
  end

  rv32iex_regfile u_regfile (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_go),
    .rs1_idx    (in_if.instruction[19:15]),
    .rs2_idx    (in_if.instruction[24:20]),
    .wr         (rf_wr_g),
    .rs1_data_r (rs1_data_r),
    .rs2_data_r (rs2_data_r)
  );

  rv32iex_exec u_exec (
    .kind      (kind_r),
    .insn      (insn_r),
    .load_data (ld_data_r),
    .rs1       (rs1_data_r),
    .rs2       (rs2_data_r),
    .pc        (pc_r),
    .halted    (halted_r),
    .pend      (pend_r),
    .pend_dest (pend_dest_r),
    .pend_type (pend_type_r),
    .res       (res),
    .upd       (upd),
    .wr        (rf_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= RESET_PC_DEFAULT;
      halted_r    <= 1'b0;
      pend_r      <= 1'b0;
      pend_dest_r <= '0;
      pend_type_r <= '0;
      reset_pc_r  <= RESET_PC_DEFAULT;
    end else begin
      if (in_go) begin
        in_valid_r <= 1'b1;
      end else if (ex_go) begin
        in_valid_r <= 1'b0;
      end
      if (ex_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ex_go) begin
        pc_r <= res.npc;
        if (upd.halt_set) begin
          halted_r <= 1'b1;
        end
        if (upd.pend_set) begin
          pend_r      <= 1'b1;
          pend_dest_r <= upd.pend_dest;
          pend_type_r <= upd.pend_type;
        end else if (upd.pend_clr) begin
          pend_r <= 1'b0;
        end
      end
      if (cfg_wr && (paddr[2] == CFG_SEL_RESET_PC)) begin
        reset_pc_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      kind_r    <= in_if.kind;
      insn_r    <= in_if.instruction;
      ld_data_r <= in_if.load_data;
    end
    if (ex_go) begin
      res_r <= res;
    end
  end

endmodule

// ----- rtl/rv32iex_checker.sv -----
// ----------------------------------------------------------------------------
// rv32iex_checker
// port-level checks of the rv32i execute unit result channel
// ----------------------------------------------------------------------------
`include "rv32i_instruction_execute_unit_macros.svh"

module rv32iex_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [2:0]                   status,
  input logic [rv32iex_pkg::XLEN-1:0] next_pc,
  input logic [1:0]                   mem_op,
  input logic [1:0]                   mem_size,
  input logic [rv32iex_pkg::XLEN-1:0] mem_address,
  input logic [rv32iex_pkg::XLEN-1:0] mem_write_data
);
  import rv32iex_pkg::*;

  // stalled word holds
  `RV32IEX_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(next_pc) && $stable(mem_address))

  // read request exactly when a load goes out
  `RV32IEX_ASSERT_IMP(a_load_read, clk, rst_n, out_valid, (status == ST_LOAD) == (mem_op == MEM_READ))

  // no request leaves address, size and data at zero
  `RV32IEX_ASSERT_IMP(a_idle_zero, clk, rst_n, out_valid && (mem_op == MEM_NONE), (mem_size == SZ_BYTE) && (mem_address == '0) && (mem_write_data == '0))

  // halted or ignored words carry no memory request
  `RV32IEX_ASSERT_IMP(a_stop_quiet, clk, rst_n, out_valid && ((status == ST_SYS) || (status == ST_ILLEGAL) || (status == ST_IGNORED)), mem_op == MEM_NONE)

endmodule

bind rv32i_instruction_execute_unit rv32iex_checker u_rv32iex_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .status         (out_if.status),
  .next_pc        (out_if.next_pc),
  .mem_op         (out_if.mem_op),
  .mem_size       (out_if.mem_size),
  .mem_address    (out_if.mem_address),
  .mem_write_data (out_if.mem_write_data)
);

// ----- sim/tb_rv32i_instruction_execute_unit.sv -----
// ----------------------------------------------------------------------------
// tb_rv32i_instruction_execute_unit
// Runs rv32i instruction and load-return words through the execute unit and
// compares every result word, field by field, with a shadow core that keeps
// its own registers, pc, halt and pending-load state. Starts with directed
// corner words, then runs constrained-random programs with bursty input,
// random output stalls and one long output hold-off. The run ends with a
// halting word followed by words that the unit must ignore. The reset_pc
// register is written and read back between phases.
// ----------------------------------------------------------------------------
module tb_rv32i_instruction_execute_unit;
  import rv32iex_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [CFG_AW-1:0] RESET_PC_ADDR = '0;

  localparam logic [2:0] F3_SB    = 3'd0;
  localparam logic [2:0] F3_SH    = 3'd1;
  localparam logic [2:0] F3_SW    = 3'd2;
  localparam logic [2:0] F3_JALR  = 3'd0;
  localparam logic [2:0] F3_CSRRW = 3'd1;
  localparam logic [11:0] F12_ECALL  = 12'h000;
  localparam logic [11:0] F12_EBREAK = 12'h001;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0F;

  class rv32i_shadow_core;
    logic [31:0] gpr [REG_COUNT];
    logic [31:0] pc;
    logic [31:0] reset_pc;
    bit halted;
    bit load_wait;
    logic [4:0] load_rd;
    logic [2:0] load_f3;
    exe_res_t pending_results[$];
    int unsigned mismatches;
    int unsigned n_insn;
    int unsigned n_ldret;
    int unsigned n_checked;
    int unsigned n_status [5];

    function new();
      reset_pc = RESET_PC_DEFAULT;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (n_status[i]) n_status[i] = 0;
      pc = reset_pc;
      halted = 0;
      load_wait = 0;
      load_rd = '0;
      load_f3 = '0;
      mismatches = 0;
      n_insn = 0;
      n_ldret = 0;
      n_checked = 0;
    endfunction

    function logic [31:0] rd_gpr(logic [4:0] idx);
      if (idx == 0 || idx >= REG_COUNT) return '0;
      return gpr[idx];
    endfunction

    function void wr_gpr(logic [4:0] idx, logic [31:0] v);
      if (idx != 0 && idx < REG_COUNT) gpr[idx] = v;
    endfunction

    function logic [31:0] alu(logic [2:0] f3, bit alt, logic [31:0] a, logic [31:0] b);
      case (f3)
        F3_ADD:  return alt ? a - b : a + b;
        F3_SLL:  return a << b[4:0];
        F3_SLT:  return {31'b0, $signed(a) < $signed(b)};
        F3_SLTU: return {31'b0, a < b};
        F3_XOR:  return a ^ b;
        F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
        F3_OR:   return a | b;
        default: return a & b;
      endcase
    endfunction

    function void take_word(bit kind, logic [31:0] w, logic [31:0] ld);
      exe_res_t r;
      logic [6:0] opc;
      logic [4:0] rd;
      logic [2:0] f3;
      logic [6:0] f7;
      logic [31:0] a, b, imm_i, imm, v;
      bit ok, take;
      r = '0;
      r.status = ST_IGNORED;
      r.npc = pc;
      if (kind) n_ldret++;
      else n_insn++;
      if (halted || kind != load_wait) begin
        // ignored word, no state change
      end else if (kind) begin
        case (load_f3)
          F3_LB:   v = {{24{ld[7]}}, ld[7:0]};
          F3_LH:   v = {{16{ld[15]}}, ld[15:0]};
          F3_LBU:  v = {24'b0, ld[7:0]};
          F3_LHU:  v = {16'b0, ld[15:0]};
          default: v = ld;
        endcase
        wr_gpr(load_rd, v);
        load_wait = 0;
        r.status = ST_DONE;
      end else begin
        opc = w[6:0];
        rd = w[11:7];
        f3 = w[14:12];
        f7 = w[31:25];
        a = rd_gpr(w[19:15]);
        b = rd_gpr(w[24:20]);
        imm_i = {{20{w[31]}}, w[31:20]};
        ok = 1;
        take = 0;
        r.status = ST_DONE;
        r.npc = pc + 32'd4;
        case (opc)
          OPC_OP: begin
            ok = f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR));
            if (ok) wr_gpr(rd, alu(f3, f7 == F7_ALT, a, b));
          end
          OPC_OPIMM: begin
            if (f3 == F3_SLL) ok = f7 == F7_BASE;
            else if (f3 == F3_SR) ok = f7 == F7_BASE || f7 == F7_ALT;
            if (ok) wr_gpr(rd, alu(f3, f3 == F3_SR && f7 == F7_ALT, a, imm_i));
          end
          OPC_LOAD: begin
            ok = f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU};
            if (ok) begin
              load_wait = 1;
              load_rd = rd;
              load_f3 = f3;
              r.status = ST_LOAD;
              r.mem_op = MEM_READ;
              r.mem_size = f3[1:0];
              r.mem_address = a + imm_i;
            end
          end
          OPC_STORE: begin
            ok = f3 inside {F3_SB, F3_SH, F3_SW};
            if (ok) begin
              r.mem_op = MEM_WRITE;
              r.mem_size = f3[1:0];
              r.mem_address = a + {{20{w[31]}}, w[31:25], w[11:7]};
              r.mem_write_data = f3 == F3_SB ? {24'b0, b[7:0]} :
                                 f3 == F3_SH ? {16'b0, b[15:0]} : b;
            end
          end
          OPC_BRANCH: begin
            imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            case (f3)
              F3_BEQ:  take = a == b;
              F3_BNE:  take = a != b;
              F3_BLT:  take = $signed(a) < $signed(b);
              F3_BGE:  take = $signed(a) >= $signed(b);
              F3_BLTU: take = a < b;
              F3_BGEU: take = a >= b;
              default: ok = 0;
            endcase
            if (ok && take) r.npc = pc + imm;
          end
          OPC_JALR: begin
            ok = f3 == F3_JALR;
            if (ok) begin
              r.npc = (a + imm_i) & ~32'd1;
              wr_gpr(rd, pc + 32'd4);
            end
          end
          OPC_LUI:   wr_gpr(rd, {w[31:12], 12'b0});
          OPC_AUIPC: wr_gpr(rd, pc + {w[31:12], 12'b0});
          OPC_JAL: begin
            imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            wr_gpr(rd, pc + 32'd4);
            r.npc = pc + imm;
          end
          OPC_SYSTEM: begin
            if (f3 == F3_PRIV) begin
              halted = 1;
              r.status = ST_SYS;
            end
          end
          default: ok = 0;
        endcase
        if (!ok) begin
          halted = 1;
          r = '0;
          r.status = ST_ILLEGAL;
          r.npc = pc;
        end
        pc = r.npc;
      end
      n_status[r.status]++;
      pending_results.push_back(r);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s: got %h, want %h", name, got, want));
    endtask

    task retire_result(exe_res_t got);
      exe_res_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result word with nothing expected, status %0d", got.status));
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        cmp_field("status", got.status, want.status);
        cmp_field("next_pc", got.npc, want.npc);
        cmp_field("mem_op", got.mem_op, want.mem_op);
        cmp_field("mem_size", got.mem_size, want.mem_size);
        cmp_field("mem_address", got.mem_address, want.mem_address);
        cmp_field("mem_write_data", got.mem_write_data, want.mem_write_data);
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rv32iex_in_if in_ch ();
  rv32iex_out_if out_ch ();

  rv32i_instruction_execute_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rv32i_shadow_core shadow;
  exe_res_t seen_word;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned hold_left;
  int unsigned mode_left;
  int unsigned rx_mode;
  bit sender_idles;
  bit holdoff_req;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall patterns, plus one long hold-off on request
  always @(negedge clk) begin
    if (holdoff_req) begin
      holdoff_req = 0;
      hold_left = 120;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= $urandom_range(0, 9) != 0;
        default: out_ch.ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      seen_word.status = out_ch.status;
      seen_word.npc = out_ch.next_pc;
      seen_word.mem_op = out_ch.mem_op;
      seen_word.mem_size = out_ch.mem_size;
      seen_word.mem_address = out_ch.mem_address;
      seen_word.mem_write_data = out_ch.mem_write_data;
      shadow.retire_result(seen_word);
    end
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [4:0] rs2, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [2:0] f3, logic [4:0] rs1,
                                        logic [4:0] rs2);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [2:0] f3, logic [4:0] rs1,
                                        logic [4:0] rs2);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] opc);
    return {imm, rd, opc};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  // at least a quarter of the picks land on x0..x3 so operands collide often
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 3));
    return 5'($urandom_range(0, 31));
  endfunction

  // legal, non-halting instruction with random content
  function automatic logic [31:0] pick_insn();
    logic [2:0] f3;
    logic [6:0] f7;
    logic [31:0] w;
    f3 = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        f7 = ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(0, 1)) ? F7_ALT : F7_BASE;
        w = enc_r(f7, f3, pick_reg(), pick_reg(), pick_reg(), OPC_OP);
      end
      4, 5, 6: begin
        w = enc_i(12'($urandom), f3, pick_reg(), pick_reg(), OPC_OPIMM);
        if (f3 == F3_SLL) w[31:25] = F7_BASE;
        else if (f3 == F3_SR) w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
      end
      7, 8, 9: begin
        case ($urandom_range(0, 4))
          0: f3 = F3_LB;
          1: f3 = F3_LH;
          2: f3 = F3_LW;
          3: f3 = F3_LBU;
          default: f3 = F3_LHU;
        endcase
        w = enc_i(12'($urandom), f3, pick_reg(), pick_reg(), OPC_LOAD);
      end
      10, 11: w = enc_s(12'($urandom), 3'($urandom_range(F3_SB, F3_SW)), pick_reg(),
                        pick_reg());
      12, 13, 14: begin
        while (!(f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU}))
          f3 = 3'($urandom_range(0, 7));
        w = enc_b(13'($urandom), f3, pick_reg(), pick_reg());
      end
      15: w = enc_j(21'($urandom), pick_reg());
      16: w = enc_i(12'($urandom), F3_JALR, pick_reg(), pick_reg(), OPC_JALR);
      17: w = enc_u(20'($urandom), pick_reg(), OPC_LUI);
      18: w = enc_u(20'($urandom), pick_reg(), OPC_AUIPC);
      default: begin
        while (f3 == F3_PRIV) f3 = 3'($urandom_range(0, 7));
        w = enc_i(12'($urandom), f3, pick_reg(), pick_reg(), OPC_SYSTEM);
      end
    endcase
    return w;
  endfunction

  task automatic offer_word(input bit kind, input logic [31:0] insn, input logic [31:0] data);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0 && sender_idles) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.instruction <= insn;
    in_ch.load_data <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    shadow.take_word(kind, insn, data);
  endtask

  task automatic settle(input int unsigned limit);
    int unsigned waited;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (shadow.pending_results.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (shadow.pending_results.size() != 0) begin
      shadow.report($sformatf("%0d result words never arrived",
                              shadow.pending_results.size()));
      shadow.pending_results.delete();
    end
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= RESET_PC_ADDR;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // reset_pc does not feed the pc in this unit, so the pc stream is unaffected
  task automatic program_reset_pc(input logic [31:0] v);
    logic [31:0] rb;
    apb_access(1'b1, v, rb);
    shadow.reset_pc = v;
    apb_access(1'b0, '0, rb);
    shadow.cmp_field("reset_pc readback", rb, shadow.reset_pc);
  endtask

  // mostly well-formed: a load is normally followed by its data word
  task automatic run_random(input int unsigned count);
    int unsigned useful;
    logic [31:0] data;
    useful = 0;
    while (useful < count || shadow.load_wait) begin
      if (useful != 0 && useful % 100 == 0) sender_idles = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 7))
        0: data = '0;
        1: data = '1;
        2: data = 32'h8000_0000;
        3: data = 32'h0000_0080;
        4: data = 32'h0000_8000;
        default: data = $urandom;
      endcase
      if (shadow.load_wait) begin
        if ($urandom_range(0, 19) == 0) begin
          offer_word(1'b0, pick_insn(), data);
        end else begin
          offer_word(1'b1, $urandom, data);
          useful++;
        end
      end else if ($urandom_range(0, 29) == 0) begin
        offer_word(1'b1, $urandom, data);
      end else begin
        offer_word(1'b0, pick_insn(), $urandom);
        useful++;
      end
    end
  endtask

  initial begin
    logic [31:0] rb;
    logic [31:0] w;
    logic [6:0] opc;
    logic [6:0] f7;
    logic [2:0] f3;
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.instruction = '0;
    in_ch.load_data = '0;
    out_ch.ready = 1'b0;
    cycle_count = 0;
    burst_left = 0;
    hold_left = 0;
    mode_left = 0;
    rx_mode = 0;
    sender_idles = 1;
    holdoff_req = 0;
    shadow = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    apb_access(1'b0, '0, rb);
    shadow.cmp_field("reset_pc after reset", rb, shadow.reset_pc);
    program_reset_pc(32'hFFFF_FFFF);

    // directed corners
    offer_word(1'b0, enc_u(20'hFFFFF, 5'd1, OPC_LUI), $urandom);
    offer_word(1'b0, enc_i(12'h7FF, F3_ADD, 5'd1, 5'd1, OPC_OPIMM), $urandom);
    offer_word(1'b0, enc_i(12'hFFF, F3_ADD, 5'd2, 5'd0, OPC_OPIMM), $urandom);
    offer_word(1'b0, enc_r(F7_BASE, F3_ADD, 5'd0, 5'd2, 5'd2, OPC_OP), $urandom);
    offer_word(1'b0, enc_r(F7_ALT, F3_ADD, 5'd3, 5'd0, 5'd2, OPC_OP), $urandom);
    offer_word(1'b0, enc_i({F7_ALT, 5'd31}, F3_SR, 5'd4, 5'd1, OPC_OPIMM), $urandom);
    offer_word(1'b0, enc_r(F7_ALT, F3_SR, 5'd5, 5'd1, 5'd3, OPC_OP), $urandom);
    offer_word(1'b0, enc_r(F7_BASE, F3_SLT, 5'd6, 5'd1, 5'd3, OPC_OP), $urandom);
    offer_word(1'b0, enc_r(F7_BASE, F3_SLTU, 5'd7, 5'd1, 5'd3, OPC_OP), $urandom);
    offer_word(1'b0, enc_i(12'h800, F3_LB, 5'd8, 5'd2, OPC_LOAD), $urandom);
    offer_word(1'b1, $urandom, 32'h0000_0080);
    offer_word(1'b0, enc_i(12'h7FF, F3_LHU, 5'd9, 5'd0, OPC_LOAD), $urandom);
    // instruction while the load is still open
    offer_word(1'b0, enc_u(20'h12345, 5'd9, OPC_LUI), $urandom);
    offer_word(1'b1, $urandom, 32'hFFFF_8000);
    offer_word(1'b0, enc_s(12'hFFF, F3_SW, 5'd1, 5'd2), $urandom);
    offer_word(1'b0, enc_s(12'h000, F3_SB, 5'd2, 5'd1), $urandom);
    offer_word(1'b0, enc_b(13'h1000, F3_BEQ, 5'd0, 5'd0), $urandom);
    offer_word(1'b0, enc_b(13'h0FFE, F3_BNE, 5'd0, 5'd0), $urandom);
    offer_word(1'b0, enc_j(21'h0FFFFE, 5'd1), $urandom);
    offer_word(1'b0, enc_i(12'hFFF, F3_JALR, 5'd5, 5'd2, OPC_JALR), $urandom);
    offer_word(1'b0, enc_u(20'h80000, 5'd10, OPC_AUIPC), $urandom);
    offer_word(1'b0, enc_i(12'hFFF, F3_CSRRW, 5'd11, 5'd2, OPC_SYSTEM), $urandom);
    // load data with no load open
    offer_word(1'b1, $urandom, $urandom);
    offer_word(1'b0, enc_b(13'h0004, F3_BLTU, 5'd3, 5'd2), $urandom);
    settle(5000);
    program_reset_pc(32'h0000_0000);

    run_random(275);
    settle(5000);
    program_reset_pc($urandom);

    // long receiver hold-off while the sender keeps pushing
    sender_idles = 0;
    holdoff_req = 1;
    run_random(275);
    settle(5000);
    program_reset_pc(RESET_PC_DEFAULT);

    sender_idles = 1;
    f3 = 3'($urandom);
    f7 = 7'($urandom);
    opc = 7'($urandom);
    case ($urandom_range(0, 10))
      0: w = enc_i(F12_ECALL, F3_PRIV, pick_reg(), pick_reg(), OPC_SYSTEM);
      1: w = enc_i(F12_EBREAK, F3_PRIV, pick_reg(), pick_reg(), OPC_SYSTEM);
      2: w = enc_i(12'($urandom), f3, pick_reg(), pick_reg(), OPC_MISC_MEM);
      3: begin
        while (opc inside {OPC_OP, OPC_OPIMM, OPC_LOAD, OPC_JALR, OPC_STORE, OPC_BRANCH,
                           OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_SYSTEM})
          opc = 7'($urandom);
        w = $urandom;
        w[6:0] = opc;
      end
      4: begin
        while (f7 inside {F7_BASE, F7_ALT}) f7 = 7'($urandom);
        w = enc_r(f7, f3, pick_reg(), pick_reg(), pick_reg(), OPC_OP);
      end
      5: begin
        while (f3 inside {F3_ADD, F3_SR}) f3 = 3'($urandom);
        w = enc_r(F7_ALT, f3, pick_reg(), pick_reg(), pick_reg(), OPC_OP);
      end
      6: begin
        f3 = $urandom_range(0, 1) ? F3_SLL : F3_SR;
        while (f7 == F7_BASE || (f3 == F3_SR && f7 == F7_ALT)) f7 = 7'($urandom);
        w = enc_i({f7, 5'($urandom)}, f3, pick_reg(), pick_reg(), OPC_OPIMM);
      end
      7: begin
        while (f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}) f3 = 3'($urandom);
        w = enc_i(12'($urandom), f3, pick_reg(), pick_reg(), OPC_LOAD);
      end
      8: begin
        while (f3 inside {F3_SB, F3_SH, F3_SW}) f3 = 3'($urandom);
        w = enc_s(12'($urandom), f3, pick_reg(), pick_reg());
      end
      9: begin
        while (f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU})
          f3 = 3'($urandom);
        w = enc_b(13'($urandom), f3, pick_reg(), pick_reg());
      end
      default: begin
        while (f3 == F3_JALR) f3 = 3'($urandom);
        w = enc_i(12'($urandom), f3, pick_reg(), pick_reg(), OPC_JALR);
      end
    endcase
    offer_word(1'b0, w, $urandom);
    // everything after the halt is ignored
    repeat (6) offer_word(1'($urandom_range(0, 1)), pick_insn(), $urandom);
    settle(5000);

    $display("covered %0d instruction words and %0d load-data words, %0d results compared",
             shadow.n_insn, shadow.n_ldret, shadow.n_checked);
    $display("results: %0d done, %0d load, %0d syscall halt, %0d illegal halt, %0d ignored",
             shadow.n_status[ST_DONE], shadow.n_status[ST_LOAD], shadow.n_status[ST_SYS],
             shadow.n_status[ST_ILLEGAL], shadow.n_status[ST_IGNORED]);
    if (shadow.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", shadow.mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
